FILE: src/bfp_pkg.sv
// Shared types and constants for the 24-bit word bit-field packer.
// Used by every module under src; depends on nothing.
package bfp_pkg;

  localparam int WORD_BITS = 24;
  localparam int WIDTH_W   = 5;
  localparam int CAP_W     = 11;
  localparam int QDEPTH    = 4;

  localparam logic [WIDTH_W-1:0]   WORD_BITS_W = WIDTH_W'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] WORD_ONES   = {WORD_BITS{1'b1}};
  localparam logic [CAP_W-1:0]     CAP_RESET   = 11'd1024;

  localparam logic CMD_APPEND      = 1'b0;
  localparam logic CMD_FLUSH       = 1'b1;
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [WIDTH_W-1:0]   field_width;
    logic [WORD_BITS-1:0] field_value;
  } bfp_in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] packed_word;
    logic                 status;
  } bfp_out_t;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_FLUSH,
    OP_NOP
  } bfp_op_t;

  // Classified item as it waits in the queue
  typedef struct packed {
    bfp_op_t              op;
    logic [WIDTH_W-1:0]   width;
    logic [WORD_BITS-1:0] value;
  } bfp_qent_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    bfp_qent_t ent;
  } bfp_qhead_t;

endpackage

FILE: src/bit_field_packer_24bit_words_top.sv
// An accepted item is written into the queue; its result is registered in the
// output register as it leaves. Throughput: one item per cycle while the queue
// has room; the four-entry queue keeps accepting while the output register
// waits on out_ready. Items with no result still pass the queue and packing stage.
// Reset (synchronous, rst_n low): empty partial word, zero word count, not
// full, capacity 1024, queue and output empty.
module bit_field_packer_24bit_words_top #(
  parameter int MAX_WORDS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bfp_pkg::bfp_in_t          in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bfp_pkg::bfp_out_t         out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bfp_pkg::CAP_W-1:0] cfg_capacity_words
);
  import bfp_pkg::*;

  bfp_qent_t  front_ent;
  bfp_qhead_t q_head;
  logic       q_pop;

  assign cfg_ready = 1'b1;

  bfp_front u_front (
    .in_item (in_item),
    .ent     (front_ent)
  );

  bfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_ent   (front_ent),
    .head       (q_head),
    .pop        (q_pop)
  );

  bfp_back #(
    .MAX_WORDS (MAX_WORDS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_capacity_words (cfg_capacity_words),
    .head               (q_head),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_item           (out_item)
  );

endmodule

FILE: src/bfp_front.sv
// Front end: classifies an incoming item into a queue entry.
// Saturates the width, masks the value. Depends on bfp_pkg.
module bfp_front (
  input  bfp_pkg::bfp_in_t   in_item,
  output bfp_pkg::bfp_qent_t ent
);
  import bfp_pkg::*;

  logic [WIDTH_W-1:0] width_sat;

  always_comb begin
    width_sat = in_item.field_width;
    if (in_item.field_width inside {[WORD_BITS + 1 : (1 << WIDTH_W) - 1]}) begin
      width_sat = WORD_BITS_W;
    end

    ent.width = width_sat;
    ent.value = in_item.field_value & ~(WORD_ONES << width_sat);
    case (in_item.command)
      CMD_APPEND: begin
        ent.op = (width_sat == '0) ? OP_NOP : OP_APPEND;
      end
      CMD_FLUSH: begin
        ent.op    = OP_FLUSH;
        ent.value = '0;
      end
      default: begin
        ent.op = OP_NOP;
      end
    endcase
  end

endmodule

FILE: src/bfp_queue.sv
// Short queue between front and back ends.
// Register-based, push and pop in the same cycle. Depends on bfp_pkg.
module bfp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  bfp_pkg::bfp_qent_t  push_ent,
  output bfp_pkg::bfp_qhead_t head,
  input  logic                pop
);
  import bfp_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QDEPTH);

  bfp_qent_t         mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != DEPTH_C);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.ent   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

FILE: src/bfp_back.sv
// Back end: packing state, capacity check and output register.
// Takes one queue entry per cycle unless a result waits on out_ready. Depends on bfp_pkg.
module bfp_back #(
  parameter int MAX_WORDS = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic [bfp_pkg::CAP_W-1:0] cfg_capacity_words,
  input  bfp_pkg::bfp_qhead_t     head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output bfp_pkg::bfp_out_t       out_item
);
  import bfp_pkg::*;

  localparam int WCNT_W = $clog2(MAX_WORDS + 1);
  localparam int CMP_W  = (WCNT_W > CAP_W) ? WCNT_W : CAP_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_WORDS);

  logic [CAP_W-1:0]     capacity_r;
  logic [WORD_BITS-1:0] partial_r, partial_nxt;
  logic [WIDTH_W-1:0]   fill_r, fill_nxt;
  logic [WCNT_W-1:0]    words_r, words_nxt;
  logic                 full_r, full_nxt;
  logic                 out_valid_r, out_valid_nxt;
  bfp_out_t             out_item_r, out_item_nxt;

  logic [WIDTH_W-1:0]   eff_width, take, rem;
  logic [WIDTH_W:0]     total;
  logic [CMP_W-1:0]     cap_ext, eff_cap;
  logic                 has_space, step;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign step      = head.valid && (!out_valid_r || out_ready);
  assign pop       = step;

  always_comb begin
    cap_ext   = CMP_W'(capacity_r);
    eff_cap   = (cap_ext > MAX_CMP) ? MAX_CMP : cap_ext;
    has_space = CMP_W'(words_r) < eff_cap;

    // Flush appends zeros up to the word boundary
    eff_width = (head.ent.op == OP_FLUSH) ? WORD_BITS_W - fill_r : head.ent.width;
    total     = {1'b0, fill_r} + {1'b0, eff_width};
    take      = WORD_BITS_W - fill_r;
    rem       = WIDTH_W'(total - (WIDTH_W + 1)'(WORD_BITS));

    partial_nxt   = partial_r;
    fill_nxt      = fill_r;
    words_nxt     = words_r;
    full_nxt      = full_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (step) begin
      if (full_r) begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.packed_word = '0;
        out_item_nxt.status      = STATUS_NO_SPACE;
      end else if (head.ent.op == OP_NOP) begin
        // drop
      end else if (head.ent.op == OP_FLUSH && fill_r == '0) begin
        // empty flush: drop
      end else if (total < (WIDTH_W + 1)'(WORD_BITS)) begin
        partial_nxt = (partial_r << eff_width) | head.ent.value;
        fill_nxt    = total[WIDTH_W-1:0];
      end else if (!has_space) begin
        full_nxt                 = 1'b1;
        out_valid_nxt            = 1'b1;
        out_item_nxt.packed_word = '0;
        out_item_nxt.status      = STATUS_NO_SPACE;
      end else begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.packed_word = (partial_r << take) | (head.ent.value >> rem);
        out_item_nxt.status      = STATUS_OK;
        words_nxt                = words_r + 1'b1;
        partial_nxt              = head.ent.value & ~(WORD_ONES << rem);
        fill_nxt                 = rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_RESET;
      partial_r   <= '0;
      fill_r      <= '0;
      words_r     <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity_r <= cfg_capacity_words;
      end
      partial_r   <= partial_nxt;
      fill_r      <= fill_nxt;
      words_r     <= words_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

`ifndef ASSERT_OFF
  a_fill_below_word: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < WORD_BITS_W)
    else $error("fill count reached a full word");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("full flag cleared without reset");

  a_words_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(words_r) <= MAX_CMP)
    else $error("word count exceeds buffer size");

  a_full_reports: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full_r) |-> out_valid_r && out_item_r.status == STATUS_NO_SPACE)
    else $error("full flag set without a no-space result");

  a_no_space_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status == STATUS_NO_SPACE |-> out_item_r.packed_word == '0)
    else $error("no-space result carries a nonzero word");
`endif

endmodule

FILE: bench/bfp_checker.sv
`timescale 1ns / 100ps
// Checker for the 24-bit word bit-field packer: watches the item, result and
// capacity channels, predicts each result and compares. Depends on bfp_pkg.
module bfp_checker #(
  parameter int MAX_WORDS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  bfp_pkg::bfp_in_t          in_item,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  bfp_pkg::bfp_out_t         out_item,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [bfp_pkg::CAP_W-1:0] cfg_capacity_words,
  output int                        pending,
  output int                        fail_count
);
  import bfp_pkg::*;

  // Shadow of the packer state
  logic [WORD_BITS-1:0] acc_bits;
  int                   acc_fill;
  int                   word_total;
  logic                 buf_full;
  logic [CAP_W-1:0]     cap_limit;

  bfp_out_t word_q[$];
  int       errs = 0;

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  function automatic bit pack_field(input int w_in, input logic [WORD_BITS-1:0] v_in,
                                    output bfp_out_t res);
    int                   w;
    int                   total;
    int                   take;
    int                   rem;
    int                   cap;
    logic [WORD_BITS-1:0] v;
    res = '0;
    if (buf_full) begin
      res.status = STATUS_NO_SPACE;
      return 1'b1;
    end
    if (w_in == 0) return 1'b0;
    w = (w_in > WORD_BITS) ? WORD_BITS : w_in;
    v = v_in & ~(WORD_ONES << w);
    total = acc_fill + w;
    if (total < WORD_BITS) begin
      acc_bits = (acc_bits << w) | v;
      acc_fill = total;
      return 1'b0;
    end
    cap = (int'(cap_limit) > MAX_WORDS) ? MAX_WORDS : int'(cap_limit);
    // No room: discard the whole item, keep the partial word
    if (word_total >= cap) begin
      buf_full   = 1'b1;
      res.status = STATUS_NO_SPACE;
      return 1'b1;
    end
    take = WORD_BITS - acc_fill;
    rem  = w - take;
    res.packed_word = (acc_bits << take) | (v >> rem);
    res.status      = STATUS_OK;
    word_total++;
    acc_bits = v & ~(WORD_ONES << rem);
    acc_fill = rem;
    return 1'b1;
  endfunction

  function automatic bit pack_item(input bfp_in_t it, output bfp_out_t res);
    res = '0;
    if (it.command == CMD_FLUSH) begin
      if (buf_full) begin
        res.status = STATUS_NO_SPACE;
        return 1'b1;
      end
      if (acc_fill == 0) return 1'b0;
      return pack_field(WORD_BITS - acc_fill, '0, res);
    end
    return pack_field(int'(it.field_width), it.field_value, res);
  endfunction

  always @(posedge clk) begin
    bfp_out_t want;
    bfp_out_t got;
    if (!rst_n) begin
      acc_bits   = '0;
      acc_fill   = 0;
      word_total = 0;
      buf_full   = 1'b0;
      cap_limit  = CAP_RESET;
      word_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap_limit = cfg_capacity_words;
      // Retire the oldest expectation before queuing a new one
      if (out_valid && out_ready) begin
        got = out_item;
        if (word_q.size() == 0) begin
          $error("unexpected result: packed_word %06h status %0d",
                 got.packed_word, got.status);
          errs++;
        end else begin
          want = word_q.pop_front();
          if (got.packed_word !== want.packed_word) begin
            $error("packed_word mismatch: expected %06h, actual %06h",
                   want.packed_word, got.packed_word);
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (pack_item(in_item, want)) word_q.push_back(want);
      end
    end
    pending    <= word_q.size();
    fail_count <= errs;
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the bit-field packer bench: clock, reset, item and capacity stimulus,
// watchdog and verdict. Depends on bfp_pkg, bfp_checker and the packer top.
module tb_top;
  import bfp_pkg::*;

  localparam int MAX_WORDS  = 1024;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 12;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  bfp_in_t          in_item = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  bfp_out_t         out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_capacity_words = '0;

  int pending;
  int fail_count;
  int snd_idle = 28;
  int rcv_idle = 77;
  int items_sent = 0;
  int words_ok = 0;
  int no_space_n = 0;
  int quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bit_field_packer_24bit_words_top #(
    .MAX_WORDS(MAX_WORDS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_item            (in_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_item           (out_item),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity_words (cfg_capacity_words)
  );

  bfp_checker #(
    .MAX_WORDS(MAX_WORDS)
  ) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_item            (in_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_item           (out_item),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity_words (cfg_capacity_words),
    .pending            (pending),
    .fail_count         (fail_count)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // Count emitted words so the capacity can be set just above them
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (out_item.status == STATUS_OK) words_ok <= words_ok + 1;
      else no_space_n <= no_space_n + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bfp_in_t mk_item(input logic cmd, input int w, input int v);
    bfp_in_t it;
    it.command     = cmd;
    it.field_width = WIDTH_W'(w);
    it.field_value = WORD_BITS'(v);
    return it;
  endfunction

  function automatic bfp_in_t rand_item();
    bfp_in_t it;
    int      r;
    it.field_value = WORD_BITS'($urandom());
    it.command     = ($urandom_range(0, 99) < 10) ? CMD_FLUSH : CMD_APPEND;
    r = $urandom_range(0, 99);
    if (r < 2) it.field_width = '0;
    else if (r < 4) it.field_width = WIDTH_W'($urandom_range(25, 31));
    else if (r < 24) it.field_width = WIDTH_W'($urandom_range(1, 4));
    else it.field_width = WIDTH_W'($urandom_range(1, 24));
    return it;
  endfunction

  task automatic send_item(input bfp_in_t it);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(rand_item());
  endtask

  // Hold until every expected result is back and the pipeline has emptied
  task automatic settle_block();
    in_valid <= 1'b0;
    do begin
      do @(posedge clk); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end while (pending != 0);
  endtask

  task automatic write_capacity(input int cap);
    settle_block();
    cfg_valid          <= 1'b1;
    cfg_capacity_words <= CAP_W'(cap);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset capacity, width extremes, masking, flushes
    send_item(mk_item(CMD_APPEND, 24, 'hFFFFFF));
    send_item(mk_item(CMD_APPEND, 24, 'h000000));
    send_item(mk_item(CMD_APPEND, 1, 'h000001));
    send_item(mk_item(CMD_APPEND, 23, 'h7FFFFF));
    send_item(mk_item(CMD_FLUSH, 17, 'hABCDEF));
    send_item(mk_item(CMD_APPEND, 0, 'hFFFFFF));
    send_item(mk_item(CMD_APPEND, 5, 'h0001F5));
    send_item(mk_item(CMD_FLUSH, 0, 'h000000));
    send_item(mk_item(CMD_APPEND, 31, 'h123456));
    send_item(mk_item(CMD_APPEND, 25, 'hFFFFFF));
    send_item(mk_item(CMD_APPEND, 12, 'hFFFABC));
    send_item(mk_item(CMD_APPEND, 12, 'h000DEF));
    send_item(mk_item(CMD_APPEND, 23, 'h000001));
    send_item(mk_item(CMD_APPEND, 2, 'h000003));
    send_item(mk_item(CMD_FLUSH, 24, 'hFFFFFF));
    send_item(mk_item(CMD_APPEND, 1, 'hFFFFFE));
    send_item(mk_item(CMD_FLUSH, 1, 'h000000));
    send_item(mk_item(CMD_APPEND, 20, 'hFFFFFF));
    send_item(mk_item(CMD_APPEND, 24, 'hFFFFFF));
    send_item(mk_item(CMD_APPEND, 4, 'h000000));
    send_item(mk_item(CMD_APPEND, 8, 'h000000));
    send_item(mk_item(CMD_APPEND, 8, 'h0000FF));
    send_item(mk_item(CMD_APPEND, 8, 'h00005A));
    send_item(mk_item(CMD_FLUSH, 31, 'h555555));

    // Capacity above the hard limit
    write_capacity(2047);
    send_random(180);

    snd_idle = 77;
    rcv_idle = 28;
    write_capacity(1024);
    send_random(180);

    // Let the buffer fill up partway through this stretch
    snd_idle = 0;
    rcv_idle = 0;
    settle_block();
    write_capacity(words_ok + 20);
    send_random(100);

    // Full flag is sticky whatever the capacity
    write_capacity(0);
    send_random(20);
    write_capacity(2047);
    send_random(10);

    settle_block();
    $display("Sent %0d items (directed and random) under capacities 1024, 2047, 0 and near-full.",
             items_sent);
    $display("Got %0d packed words and %0d no-space answers.", words_ok, no_space_n);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
